/* hdl/pwt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pwt_pkg;

   localparam int ENTRIES_DEF = 32;
   localparam int RESULT_CAP  = 32;

   localparam logic KIND_STRENGTHEN = 1'b0;
   localparam logic KIND_QUERY      = 1'b1;

   localparam logic signed [31:0] WEIGHT_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] WEIGHT_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      ST_NEIGHBOUR    = 3'd0,
      ST_NONE         = 3'd1,
      ST_STRENGTHENED = 3'd2,
      ST_SELF         = 3'd3,
      ST_FULL         = 3'd4
   } status_type;

   typedef struct packed {
      logic       load_req;
      logic       start;
      logic       select;
      logic       write_entry;
      logic       load_out;
      status_type out_status;
   } cmd_type;

   typedef struct packed {
      logic in_self;
      logic req_kind;
      logic scan_done;
      logic slot_ok;
      logic count_zero;
      logic out_last;
   } sts_type;

endpackage

`default_nettype wire

/* hdl/pwt_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pwt_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] id_first;
   logic signed [31:0] id_second;
   logic signed [31:0] amount;

   modport source (output valid, kind, id_first, id_second, amount, input ready);
   modport sink   (input valid, kind, id_first, id_second, amount, output ready);
endinterface

interface pwt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] neighbour_id;
   logic signed [31:0] edge_weight_out;
   logic [2:0]         status;
   logic               last;

   modport source (output valid, neighbour_id, edge_weight_out, status, last, input ready);
   modport sink   (input valid, neighbour_id, edge_weight_out, status, last, output ready);
endinterface

`default_nettype wire

/* hdl/pwt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module pwt_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hdl/pwt_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module pwt_datapath #(
   parameter int ENTRIES = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_kind,
   input  wire logic signed [31:0] in_id_first,
   input  wire logic signed [31:0] in_id_second,
   input  wire logic signed [31:0] in_amount,
   output logic signed [31:0]      out_neighbour_id,
   output logic signed [31:0]      out_edge_weight,
   output logic [2:0]              out_status,
   output logic                    out_last,
   input  wire pwt_pkg::cmd_type   cmd,
   output pwt_pkg::sts_type        sts
);
   import pwt_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int NW = $clog2(RESULT_CAP + 1);
   localparam int DW = 96;
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   // latched item
   logic               kind_ff;
   logic signed [31:0] node_ff, lo_ff, hi_ff, amount_ff;

   // slot scanner
   logic          run_ff, run_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic          rd_vld_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          select_ff;

   logic [ENTRIES-1:0] valid_ff, cand_ff;

   logic               hit_ff, free_ff;
   logic [IW-1:0]      hit_idx_ff, free_idx_ff;
   logic signed [31:0] hit_w_ff;
   logic [CW-1:0]      count_ff;

   logic               best_ff;
   logic [IW-1:0]      best_idx_ff;
   logic signed [31:0] best_w_ff, best_other_ff;
   logic [NW-1:0]      n_ff;

   logic signed [31:0] out_id_ff, out_w_ff;
   status_type         out_status_ff;
   logic               out_last_ff;

   logic [DW-1:0]      rdata, wdata;
   logic signed [31:0] rd_lo, rd_hi, rd_w;
   logic               entry_ok, pair_hit, node_hit;
   logic signed [31:0] base_w, sat_w;
   logic signed [32:0] sum_w;
   logic [IW-1:0]      wslot;
   logic [NW-1:0]      total_cap;
   logic               last_neigh;

   assign rd_lo    = rdata[95:64];
   assign rd_hi    = rdata[63:32];
   assign rd_w     = rdata[31:0];
   assign entry_ok = valid_ff[rd_idx_ff];
   assign pair_hit = entry_ok && (rd_lo == lo_ff) && (rd_hi == hi_ff);
   assign node_hit = entry_ok && ((rd_lo == node_ff) || (rd_hi == node_ff));

   // saturating add
   always_comb begin
      base_w = hit_ff ? hit_w_ff : 32'sd0;
      sum_w  = {base_w[31], base_w} + {amount_ff[31], amount_ff};
      if (sum_w[32] != sum_w[31]) begin
         sat_w = sum_w[32] ? WEIGHT_MIN : WEIGHT_MAX;
      end else begin
         sat_w = sum_w[31:0];
      end
   end

   assign wslot = hit_ff ? hit_idx_ff : free_idx_ff;
   assign wdata = {lo_ff, hi_ff, sat_w};

   always_comb begin
      if (32'(count_ff) > 32'(RESULT_CAP)) begin
         total_cap = NW'(RESULT_CAP);
      end else begin
         total_cap = NW'(count_ff);
      end
      last_neigh = ({1'b0, n_ff} + 1'b1) == {1'b0, total_cap};
   end

   pwt_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
      .clock (clock),
      .we    (cmd.write_entry),
      .waddr (wslot),
      .wdata (wdata),
      .raddr (addr_ff),
      .rdata (rdata)
   );

   always_comb begin
      run_in  = run_ff;
      addr_in = addr_ff;
      if (cmd.start) begin
         run_in  = 1'b1;
         addr_in = '0;
      end else if (run_ff) begin
         if (addr_ff == LAST_IDX) begin
            run_in = 1'b0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         rd_vld_ff <= 1'b0;
         valid_ff  <= '0;
      end else begin
         run_ff    <= run_in;
         rd_vld_ff <= run_ff;
         if (cmd.write_entry) begin
            valid_ff[wslot] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      rd_idx_ff <= addr_ff;

      if (cmd.load_req) begin
         kind_ff   <= in_kind;
         node_ff   <= in_id_first;
         amount_ff <= in_amount;
         if (in_id_first < in_id_second) begin
            lo_ff <= in_id_first;
            hi_ff <= in_id_second;
         end else begin
            lo_ff <= in_id_second;
            hi_ff <= in_id_first;
         end
         n_ff <= '0;
      end

      if (cmd.start) begin
         select_ff <= cmd.select;
         if (cmd.select) begin
            best_ff <= 1'b0;
         end else begin
            hit_ff   <= 1'b0;
            free_ff  <= 1'b0;
            count_ff <= '0;
         end
      end else if (rd_vld_ff) begin
         if (select_ff) begin
            if (cand_ff[rd_idx_ff] && (!best_ff || rd_w > best_w_ff)) begin
               best_ff       <= 1'b1;
               best_idx_ff   <= rd_idx_ff;
               best_w_ff     <= rd_w;
               best_other_ff <= (rd_lo == node_ff) ? rd_hi : rd_lo;
            end
         end else begin
            cand_ff[rd_idx_ff] <= node_hit;
            if (node_hit) begin
               count_ff <= count_ff + 1'b1;
            end
            if (pair_hit && !hit_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= rd_idx_ff;
               hit_w_ff   <= rd_w;
            end
            if (!entry_ok && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= rd_idx_ff;
            end
         end
      end

      if (cmd.load_out) begin
         out_status_ff <= cmd.out_status;
         case (cmd.out_status)
            ST_NEIGHBOUR: begin
               out_id_ff            <= best_other_ff;
               out_w_ff             <= best_w_ff;
               out_last_ff          <= last_neigh;
               cand_ff[best_idx_ff] <= 1'b0;
               n_ff                 <= n_ff + 1'b1;
            end
            ST_STRENGTHENED: begin
               out_id_ff   <= '0;
               out_w_ff    <= sat_w;
               out_last_ff <= 1'b1;
            end
            default: begin
               out_id_ff   <= '0;
               out_w_ff    <= '0;
               out_last_ff <= 1'b1;
            end
         endcase
      end
   end

   assign sts.in_self    = (in_kind == KIND_STRENGTHEN) && (in_id_first == in_id_second);
   assign sts.req_kind   = kind_ff;
   assign sts.scan_done  = rd_vld_ff && (rd_idx_ff == LAST_IDX);
   assign sts.slot_ok    = hit_ff || free_ff;
   assign sts.count_zero = (count_ff == '0);
   assign sts.out_last   = out_last_ff;

   assign out_neighbour_id = out_id_ff;
   assign out_edge_weight  = out_w_ff;
   assign out_status       = out_status_ff;
   assign out_last         = out_last_ff;

endmodule

`default_nettype wire

/* hdl/pwt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pwt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire pwt_pkg::sts_type sts,
   output pwt_pkg::cmd_type      cmd
);
   import pwt_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_DECIDE = 6'b000100,
      S_SELECT = 6'b001000,
      S_PICK   = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.out_status = ST_NONE;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (sts.in_self) begin
                  cmd.load_out   = 1'b1;
                  cmd.out_status = ST_SELF;
                  state_in       = S_RESP;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.req_kind == KIND_QUERY) begin
               if (sts.count_zero) begin
                  cmd.load_out   = 1'b1;
                  cmd.out_status = ST_NONE;
                  state_in       = S_RESP;
               end else begin
                  cmd.start  = 1'b1;
                  cmd.select = 1'b1;
                  state_in   = S_SELECT;
               end
            end else begin
               cmd.load_out = 1'b1;
               if (sts.slot_ok) begin
                  cmd.write_entry = 1'b1;
                  cmd.out_status  = ST_STRENGTHENED;
               end else begin
                  cmd.out_status = ST_FULL;
               end
               state_in = S_RESP;
            end
         end
         S_SELECT: begin
            if (sts.scan_done) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            cmd.load_out   = 1'b1;
            cmd.out_status = ST_NEIGHBOUR;
            state_in       = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sts.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.start  = 1'b1;
                  cmd.select = 1'b1;
                  state_in   = S_SELECT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/pair_weight_table_ranked_query.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | payload
// req_ch  | in  | kind, id_first, id_second, amount
// rsp_ch  | out | neighbour_id, edge_weight_out, status, last
//
// one item at a time; a slot scan reads the table ram one slot per cycle
// strengthen: slot scan, then the entry is written if a matching or free slot
// was found (else status full); self pair: answered without a scan; query:
// a slot scan counts neighbours, then one select scan per neighbour result
// reset clears the valid bits and the controller; the table ram is not cleared
// req_ch is ready only when idle; a stalled rsp_ch holds the block

module pair_weight_table_ranked_query #(
   parameter int ENTRIES = pwt_pkg::ENTRIES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   pwt_req_if.sink   req_ch,
   pwt_rsp_if.source rsp_ch
);
   import pwt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pwt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pwt_datapath #(.ENTRIES(ENTRIES)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .in_kind          (req_ch.kind),
      .in_id_first      (req_ch.id_first),
      .in_id_second     (req_ch.id_second),
      .in_amount        (req_ch.amount),
      .out_neighbour_id (rsp_ch.neighbour_id),
      .out_edge_weight  (rsp_ch.edge_weight_out),
      .out_status       (rsp_ch.status),
      .out_last         (rsp_ch.last),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

`default_nettype wire
